// ----- src/multi_led_blink_sequencer_assert.svh -----
// ---------------------------------------------------------------------------
// Multi-LED blink sequencer assertion macros
// Short forms for the concurrent checks used in the sequencer.
// ---------------------------------------------------------------------------
`ifndef MULTI_LED_BLINK_SEQUENCER_ASSERT_SVH
`define MULTI_LED_BLINK_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MLBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, disabled during reset.
`define MLBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ----- src/mlbs_pkg.sv -----
// ---------------------------------------------------------------------------
// Multi-LED blink sequencer package
// Shared types, command and phase codes, and constants of the sequencer.
// ---------------------------------------------------------------------------
package mlbs_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int TICK_MS_DEF  = 10;

  localparam logic [12:0] LIMIT_MAX     = 13'd8191;
  localparam logic [15:0] PRESET_MS     = 16'd10000;
  localparam logic [15:0] PRESET_CYCLES = 16'd100;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_CONT  = 3'd3,
    CMD_ON    = 3'd4,
    CMD_OFF   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    PH_STOP      = 3'd0,
    PH_STOP_WAIT = 3'd1,
    PH_ON        = 3'd2,
    PH_ON_WAIT   = 3'd3,
    PH_OFF       = 3'd4,
    PH_OFF_WAIT  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_MUL,
    ST_CMD_WR,
    ST_TICK,
    ST_DONE
  } state_t;

  typedef struct packed {
    phase_t      phase;
    phase_t      saved_phase;
    logic [12:0] on_limit;
    logic [12:0] off_limit;
    logic [15:0] cycle_limit;
    logic [13:0] on_counter;
    logic [13:0] off_counter;
    logic [15:0] cycle_counter;
  } chan_rec_t;

  localparam chan_rec_t RESET_REC = '{
    phase:         PH_STOP,
    saved_phase:   PH_STOP_WAIT,
    on_limit:      13'd0,
    off_limit:     13'd0,
    cycle_limit:   16'd0,
    on_counter:    14'd0,
    off_counter:   14'd0,
    cycle_counter: 16'd0
  };

  function automatic logic is_stopped(input phase_t ph);
    return (ph == PH_STOP) || (ph == PH_STOP_WAIT);
  endfunction

endpackage

// ----- src/mlbs_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module mlbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mlbs_ms_to_ticks.sv -----
// ---------------------------------------------------------------------------
// Millisecond to tick converter
// Divides a 16-bit time by the tick period through a registered reciprocal
// multiply, then saturates the quotient to the 13-bit limit range.
// ---------------------------------------------------------------------------
module mlbs_ms_to_ticks #(
  parameter int TICK_MS = mlbs_pkg::TICK_MS_DEF
) (
  input  logic        clk,
  input  logic [15:0] ms,
  output logic [12:0] ticks
);

  import mlbs_pkg::*;

  localparam int SHIFT = 16 + $clog2(TICK_MS);
  localparam int RECIP = (2 ** SHIFT) / TICK_MS + 1;
  localparam int PW    = SHIFT + 16;

  logic [PW-1:0] prod;
  logic [15:0]   quot;

  always_ff @(posedge clk) begin
    prod <= PW'(ms) * PW'(RECIP);
  end

  assign quot  = prod[SHIFT +: 16];
  assign ticks = (quot[15:13] != 3'd0) ? LIMIT_MAX : quot[12:0];

endmodule

// ----- src/mlbs_chan_update.sv -----
// ---------------------------------------------------------------------------
// Channel record update
// Computes the new record and pin level of one channel for a command.
// ---------------------------------------------------------------------------
module mlbs_chan_update (
  input  logic [2:0]          cmd,
  input  mlbs_pkg::chan_rec_t rec_in,
  input  logic                pin_in,
  input  logic [12:0]         on_ticks,
  input  logic [12:0]         off_ticks,
  input  logic [15:0]         total,
  output mlbs_pkg::chan_rec_t rec_out,
  output logic                pin_out
);

  import mlbs_pkg::*;

  logic [13:0] on_inc;
  logic [13:0] off_inc;
  logic [15:0] cyc_inc;

  assign on_inc  = rec_in.on_counter + 14'd1;
  assign off_inc = rec_in.off_counter + 14'd1;
  assign cyc_inc = rec_in.cycle_counter + 16'd1;

  always_comb begin
    rec_out = rec_in;
    pin_out = pin_in;
    case (cmd)
      CMD_TICK: begin
        case (rec_in.phase)
          PH_STOP: begin
            pin_out       = 1'b0;
            rec_out.phase = PH_STOP_WAIT;
          end
          PH_ON: begin
            if (rec_in.on_limit == 13'd0) begin
              rec_out.phase = PH_OFF;
            end else begin
              pin_out       = 1'b1;
              rec_out.phase = PH_ON_WAIT;
            end
          end
          PH_ON_WAIT: begin
            if (on_inc > {1'b0, rec_in.on_limit}) begin
              rec_out.on_counter = 14'd0;
              rec_out.phase      = PH_OFF;
            end else begin
              rec_out.on_counter = on_inc;
            end
          end
          PH_OFF: begin
            if (rec_in.off_limit == 13'd0) begin
              rec_out.phase = PH_ON;
            end else begin
              pin_out       = 1'b0;
              rec_out.phase = PH_OFF_WAIT;
            end
          end
          PH_OFF_WAIT: begin
            if (off_inc > {1'b0, rec_in.off_limit}) begin
              rec_out.off_counter = 14'd0;
              rec_out.phase       = PH_ON;
              if (rec_in.cycle_limit != 16'd0) begin
                if (cyc_inc >= rec_in.cycle_limit) begin
                  rec_out.cycle_counter = 16'd0;
                  rec_out.phase         = PH_STOP;
                end else begin
                  rec_out.cycle_counter = cyc_inc;
                end
              end
            end else begin
              rec_out.off_counter = off_inc;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_START, CMD_ON, CMD_OFF: begin
        rec_out.on_limit      = on_ticks;
        rec_out.off_limit     = off_ticks;
        rec_out.cycle_limit   = total;
        rec_out.on_counter    = 14'd0;
        rec_out.off_counter   = 14'd0;
        rec_out.cycle_counter = 16'd0;
        rec_out.phase         = PH_ON;
      end
      CMD_STOP: begin
        rec_out.saved_phase = rec_in.phase;
        rec_out.phase       = PH_STOP;
      end
      CMD_CONT: begin
        rec_out.phase = rec_in.saved_phase;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/multi_led_blink_sequencer.sv -----
// ---------------------------------------------------------------------------
// Multi-LED blink sequencer
// Per-channel six-phase blink machines kept in one channel record RAM.
//
//   Channel   Signals                              Flow control
//   command   start, busy, command..toggle_total   beat taken on start & !busy
//   result    done, led_levels, stopped_mask       one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_data       beat on cfg_valid & cfg_ready
//
// A tick walks min(channels_in_use, CHANNELS) channels, one per cycle, for the
// record RAM read-modify-write. Start, stop, continue and preset commands with
// a valid index go through ST_CMD_MUL and ST_CMD_WR; other beats skip to
// ST_DONE. The result strobe comes in the last busy cycle. Reset is synchronous
// and needs no clearing pass: valid bits mark channel records never written.
// ---------------------------------------------------------------------------
module multi_led_blink_sequencer #(
  parameter int CHANNELS = mlbs_pkg::CHANNELS_DEF,
  parameter int TICK_MS  = mlbs_pkg::TICK_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  led_index,
  input  logic [15:0] on_ms,
  input  logic [15:0] off_ms,
  input  logic [15:0] toggle_total,
  output logic        done,
  output logic [7:0]  led_levels,
  output logic [7:0]  stopped_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  import mlbs_pkg::*;

  `include "multi_led_blink_sequencer_assert.svh"

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = ($clog2(CHANNELS + 1) > 4) ? $clog2(CHANNELS + 1) : 4;
  localparam int RW = $bits(chan_rec_t);

  state_t         state;
  state_t         state_next;
  logic [3:0]     channels_in_use;
  logic [NW-1:0]  tick_n;
  logic [2:0]     cmd_q;
  logic [IW-1:0]  idx_q;
  logic [15:0]    on_ms_q;
  logic [15:0]    off_ms_q;
  logic [15:0]    total_q;
  logic [IW-1:0]  chan;
  logic           last;
  logic           accept;
  logic           idx_ok;
  logic           is_load;
  logic [IW-1:0]  raddr;
  logic [IW-1:0]  rd_addr_q;
  logic [RW-1:0]  rdata;
  chan_rec_t      rec_in;
  chan_rec_t      rec_out;
  logic [IW-1:0]  upd_chan;
  logic           we;
  logic           pin_out;
  logic [12:0]    on_ticks;
  logic [12:0]    off_ticks;
  logic [CHANNELS-1:0] valid;
  logic [CHANNELS-1:0] pin_vec;
  logic [CHANNELS-1:0] stop_vec;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign tick_n    = (NW'(channels_in_use) > NW'(CHANNELS)) ? NW'(CHANNELS)
                                                            : NW'(channels_in_use);
  assign idx_ok    = {29'd0, led_index} < 32'(CHANNELS);
  assign is_load   = (command == CMD_START) || (command == CMD_STOP) ||
                     (command == CMD_CONT) || (command == CMD_ON) || (command == CMD_OFF);
  assign last      = (NW'(chan) + NW'(1)) == tick_n;
  assign upd_chan  = (state == ST_TICK) ? chan : idx_q;
  assign we        = (state == ST_TICK) || (state == ST_CMD_WR);
  assign rec_in    = valid[rd_addr_q] ? chan_rec_t'(rdata) : RESET_REC;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    raddr      = idx_q;
    case (state)
      ST_IDLE: begin
        busy  = 1'b0;
        raddr = (command == CMD_TICK) ? '0 : IW'(led_index);
        if (accept) begin
          if (command == CMD_TICK) begin
            state_next = (tick_n == '0) ? ST_DONE : ST_TICK;
          end else if (idx_ok && is_load) begin
            state_next = ST_CMD_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_CMD_MUL: begin
        state_next = ST_CMD_WR;
      end
      ST_CMD_WR: begin
        state_next = ST_DONE;
      end
      ST_TICK: begin
        raddr = chan + IW'(1);
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      channels_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= raddr;
    if (accept) begin
      cmd_q    <= command;
      idx_q    <= IW'(led_index);
      on_ms_q  <= (command == CMD_ON) ? PRESET_MS :
                  (command == CMD_OFF) ? 16'd0 : on_ms;
      off_ms_q <= (command == CMD_OFF) ? PRESET_MS :
                  (command == CMD_ON) ? 16'd0 : off_ms;
      total_q  <= ((command == CMD_ON) || (command == CMD_OFF)) ? PRESET_CYCLES
                                                                : toggle_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan     <= '0;
      valid    <= '0;
      pin_vec  <= '0;
      stop_vec <= '1;
    end else begin
      if (accept) begin
        chan <= '0;
      end else if ((state == ST_TICK) && !last) begin
        chan <= chan + IW'(1);
      end
      if (we) begin
        valid[upd_chan]    <= 1'b1;
        pin_vec[upd_chan]  <= pin_out;
        stop_vec[upd_chan] <= is_stopped(rec_out.phase);
      end
    end
  end

  mlbs_ram #(
    .WIDTH (RW),
    .DEPTH (CHANNELS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (we),
    .waddr (upd_chan),
    .wdata (rec_out),
    .raddr (raddr),
    .rdata (rdata)
  );

  mlbs_ms_to_ticks #(
    .TICK_MS (TICK_MS)
  ) u_on_conv (
    .clk   (clk),
    .ms    (on_ms_q),
    .ticks (on_ticks)
  );

  mlbs_ms_to_ticks #(
    .TICK_MS (TICK_MS)
  ) u_off_conv (
    .clk   (clk),
    .ms    (off_ms_q),
    .ticks (off_ticks)
  );

  mlbs_chan_update u_update (
    .cmd       (cmd_q),
    .rec_in    (rec_in),
    .pin_in    (pin_vec[upd_chan]),
    .on_ticks  (on_ticks),
    .off_ticks (off_ticks),
    .total     (total_q),
    .rec_out   (rec_out),
    .pin_out   (pin_out)
  );

  for (genvar i = 0; i < 8; i++) begin : g_out
    if (i < CHANNELS) begin : g_used
      assign led_levels[i]   = pin_vec[i];
      assign stopped_mask[i] = stop_vec[i];
    end else begin : g_unused
      assign led_levels[i]   = 1'b0;
      assign stopped_mask[i] = 1'b0;
    end
  end

  `MLBS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `MLBS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `MLBS_ASSERT_NOW(a_write_busy, clk, rst, we, busy)
  `MLBS_ASSERT_NOW(a_chan_range, clk, rst, state == ST_TICK, NW'(chan) < tick_n)

endmodule
